@@ design/sbo_pkg.sv @@
// Package for the sphere/box overlap classifier: result codes, register
// indexes and the stage-enable bundle. No dependencies.
`default_nettype none

package sbo_pkg;

	typedef enum logic [1:0] {
		REL_OUTSIDE    = 2'd0,
		REL_INTERSECTS = 2'd1,
		REL_INSIDE     = 2'd2
	} relation_t;

	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_CENTER_Z = 3'd2,
		CFG_RADIUS   = 3'd3
	} cfg_index_t;

	// Load enables, one per pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

`default_nettype wire

@@ design/sbo_axis_span.sv @@
// One axis of the classifier: nearest and farthest distance from the centre
// to the box span, registered into stage 1. Depends on sbo_pkg.
`default_nettype none

module sbo_axis_span #(
	parameter int COORD_WIDTH = 32
) (
	input  wire                        clk,
	input  sbo_pkg::pipe_en_t          en,
	input  wire  [COORD_WIDTH-1:0]     center,
	input  wire  [COORD_WIDTH-1:0]     box_min,
	input  wire  [COORD_WIDTH-1:0]     box_max,
	output logic [COORD_WIDTH:0]       near_s1,
	output logic [COORD_WIDTH:0]       far_s1
);
	import sbo_pkg::*;

	localparam int D = COORD_WIDTH + 1;

	logic signed [D-1:0] dlo;
	logic signed [D-1:0] dhi;
	logic [D-1:0]        alo;
	logic [D-1:0]        ahi;
	logic [D-1:0]        near_d;

	always_comb begin
		dlo = $signed({box_min[COORD_WIDTH-1], box_min}) - $signed({center[COORD_WIDTH-1], center});
		dhi = $signed({box_max[COORD_WIDTH-1], box_max}) - $signed({center[COORD_WIDTH-1], center});
		alo = dlo[D-1] ? D'(-dlo) : D'(dlo);
		ahi = dhi[D-1] ? D'(-dhi) : D'(dhi);
		// centre below min: min-centre; above max: centre-max
		priority if (!dlo[D-1] && (dlo != '0)) begin
			near_d = D'(dlo);
		end else if (dhi[D-1]) begin
			near_d = ahi;
		end else begin
			near_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			near_s1 <= near_d;
			far_s1  <= (alo > ahi) ? alo : ahi;
		end
	end

endmodule

`default_nettype wire

@@ design/sbo_square.sv @@
// Exact square of an unsigned value, split into half-width partial products
// (stage 2) and recombined (stage 3). Depends on sbo_pkg.
`default_nettype none

module sbo_square #(
	parameter int VAL_WIDTH = 33
) (
	input  wire                          clk,
	input  sbo_pkg::pipe_en_t            en,
	input  wire  [VAL_WIDTH-1:0]         val,
	output logic [2*VAL_WIDTH-1:0]       sq_s3
);
	import sbo_pkg::*;

	localparam int L  = VAL_WIDTH / 2;
	localparam int H  = VAL_WIDTH - L;
	localparam int SQ = 2 * VAL_WIDTH;

	logic [H-1:0]     vh;
	logic [L-1:0]     vl;
	logic [2*H-1:0]   hh_s2;
	logic [H+L-1:0]   hl_s2;
	logic [2*L-1:0]   ll_s2;

	assign vh = val[VAL_WIDTH-1:L];
	assign vl = val[L-1:0];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hh_s2 <= (2*H)'(vh) * (2*H)'(vh);
			hl_s2 <= (H+L)'(vh) * (H+L)'(vl);
			ll_s2 <= (2*L)'(vl) * (2*L)'(vl);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sq_s3 <= (SQ'(hh_s2) << (2*L)) + (SQ'(hl_s2) << (L+1)) + SQ'(ll_s2);
		end
	end

endmodule

`default_nettype wire

@@ design/sphere_box_overlap_classifier_unit.sv @@
// Top level of the sphere/box overlap classifier: config registers, stream
// handshake, five-stage pipeline. Uses sbo_pkg, sbo_axis_span, sbo_square.
//
//  channel   dir  width        beat contents (low bits first)
//  s_axis    in   6*W (bytes)  box_min_x,y,z, box_max_x,y,z; tuser = mode
//  m_axis    out  8            relation
//  cfg       in   W            centre x,y,z, radius by cfg_index
//
// One beat per cycle while the sink accepts results. Stages: span, partial
// products, squares, sums, compare into the output register.
// A stage loads whenever it is empty or the stage after it moves, so a stall
// holds every beat in place and bubbles collapse.
// Reset clears the valid bits and the sphere registers.
`default_nettype none

module sphere_box_overlap_classifier_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // min x,y,z, max x,y,z
	input  wire  [0:0]                           s_axis_tuser,  // mode
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // relation
	input  wire                                  cfg_we,
	input  wire  [sbo_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire  [COORD_WIDTH-1:0]               cfg_data
);
	import sbo_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int D  = W + 1;
	localparam int SQ = 2 * D;
	localparam int SW = SQ + 2;

	logic [W-1:0]   cx_q, cy_q, cz_q;
	logic [W-2:0]   radius_q;

	logic           v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic           rdy1, rdy2, rdy3, rdy4, rdy5;
	pipe_en_t       en;

	logic           mode_s1, mode_s2, mode_s3, mode_s4;
	logic [D-1:0]   rad_s1;
	logic [D-1:0]   near_s1 [3];
	logic [D-1:0]   far_s1  [3];
	logic [SQ-1:0]  near_sq_s3 [3];
	logic [SQ-1:0]  far_sq_s3  [3];
	logic [SQ-1:0]  r2_s3;
	logic [SW-1:0]  dist_s4, far_s4, r2_s4;
	relation_t      rel_s5;
	logic [W-1:0]   centre [3];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			radius_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER_X: cx_q     <= cfg_data;
				CFG_CENTER_Y: cy_q     <= cfg_data;
				CFG_CENTER_Z: cz_q     <= cfg_data;
				CFG_RADIUS:   radius_q <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	assign centre[0] = cx_q;
	assign centre[1] = cy_q;
	assign centre[2] = cz_q;

	// handshake
	assign rdy5 = !v5_s5 || m_axis_tready;
	assign rdy4 = !v4_s4 || rdy5;
	assign rdy3 = !v3_s3 || rdy4;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= s_axis_tvalid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (rdy5) v5_s5 <= v4_s4;
		end
	end

	// stage 1: per-axis spans
	for (genvar a = 0; a < 3; a++) begin : g_axis
		sbo_axis_span #(.COORD_WIDTH(W)) u_span (
			.clk     (clk),
			.en      (en),
			.center  (centre[a]),
			.box_min (s_axis_tdata[a*W +: W]),
			.box_max (s_axis_tdata[(a+3)*W +: W]),
			.near_s1 (near_s1[a]),
			.far_s1  (far_s1[a])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mode_s1 <= s_axis_tuser[0];
			rad_s1  <= D'(radius_q);
		end
		if (rdy2) mode_s2 <= mode_s1;
		if (rdy3) mode_s3 <= mode_s2;
		if (rdy4) mode_s4 <= mode_s3;
	end

	// stages 2-3: squares
	for (genvar a = 0; a < 3; a++) begin : g_sq
		sbo_square #(.VAL_WIDTH(D)) u_near (
			.clk (clk), .en (en), .val (near_s1[a]), .sq_s3 (near_sq_s3[a])
		);
		sbo_square #(.VAL_WIDTH(D)) u_far (
			.clk (clk), .en (en), .val (far_s1[a]), .sq_s3 (far_sq_s3[a])
		);
	end

	sbo_square #(.VAL_WIDTH(D)) u_rad (
		.clk (clk), .en (en), .val (rad_s1), .sq_s3 (r2_s3)
	);

	// stage 4: sums
	always_ff @(posedge clk) begin
		if (rdy4) begin
			dist_s4 <= SW'(near_sq_s3[0]) + SW'(near_sq_s3[1]) + SW'(near_sq_s3[2]);
			far_s4  <= SW'(far_sq_s3[0]) + SW'(far_sq_s3[1]) + SW'(far_sq_s3[2]);
			r2_s4   <= SW'(r2_s3);
		end
	end

	// stage 5: classify
	always_ff @(posedge clk) begin
		if (rdy5) begin
			priority if (dist_s4 >= r2_s4) begin
				rel_s5 <= REL_OUTSIDE;
			end else if (mode_s4) begin
				rel_s5 <= REL_INSIDE;
			end else if (far_s4 >= r2_s4) begin
				rel_s5 <= REL_INTERSECTS;
			end else begin
				rel_s5 <= REL_INSIDE;
			end
		end
	end

	assign m_axis_tvalid = v5_s5;
	assign m_axis_tdata  = {6'b0, rel_s5};

endmodule

`default_nettype wire

@@ design/sbo_checker.sv @@
// Port-level checks for the sphere/box overlap classifier, bound to the top
// level. Depends on sbo_pkg.
`default_nettype none

module sbo_checker #(
	parameter int COORD_WIDTH = 32
) (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  s_axis_tvalid,
	input wire                                  s_axis_tready,
	input wire [((6*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	input wire [0:0]                            s_axis_tuser,
	input wire                                  m_axis_tvalid,
	input wire                                  m_axis_tready,
	input wire [7:0]                            m_axis_tdata
);
	import sbo_pkg::*;

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result beat during reset");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0) &&
			(m_axis_tdata[1:0] == REL_OUTSIDE || m_axis_tdata[1:0] == REL_INTERSECTS ||
			 m_axis_tdata[1:0] == REL_INSIDE))
		else $error("illegal relation code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("stalled input beat changed");

endmodule

bind sphere_box_overlap_classifier_unit sbo_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sbo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/tb_sphere_box_overlap_classifier_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for sphere_box_overlap_classifier_unit: directed and random box
// beats under stream back-pressure, scored against a behavioural sphere/box classifier.
// Needs sbo_pkg and the unit's RTL.
`default_nettype none

module tb_sphere_box_overlap_classifier_unit;
	import sbo_pkg::*;

	localparam int CW = 32;
	localparam int TDATA_W = ((6*CW+7)/8)*8;
	localparam bit MODE_FULL = 1'b0;
	localparam bit MODE_FAST = 1'b1;
	localparam longint ONE = 64'sd65536;
	localparam longint MINV = -(64'sd1 <<< (CW-1));
	localparam longint MAXV = (64'sd1 <<< (CW-1)) - 1;

	typedef struct packed {
		logic                mode;
		logic [2:0][CW-1:0]  hi;
		logic [2:0][CW-1:0]  lo;
	} box_beat_t;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [TDATA_W-1:0]       s_axis_tdata = '0;  // min x,y,z, max x,y,z
	logic [0:0]               s_axis_tuser = '0;  // mode
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [7:0]               m_axis_tdata;       // relation
	logic                     cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [CW-1:0]            cfg_data = '0;

	logic [2:0][CW-1:0]  sphere_centre = '0;
	logic [CW-2:0]       sphere_radius = '0;

	box_beat_t  box_q[$];
	relation_t  relation_q[$];
	box_beat_t  beat_now, beat_next;
	int         burst_left = 0;
	int         gap_left = 0;
	rx_mode_t   rx_mode = RX_FREE;
	int         rx_left = 0;
	int         fail_count = 0;

	sphere_box_overlap_classifier_unit #(.COORD_WIDTH(CW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic relation_t classify_box(box_beat_t b);
		logic [129:0] near_sq, far_sq, rad_sq, w;
		longint c, lo, hi, d, m;
		near_sq = '0;
		far_sq = '0;
		rad_sq = 130'(sphere_radius) * 130'(sphere_radius);
		for (int i = 0; i < 3; i++) begin
			c = $signed(sphere_centre[i]);
			lo = $signed(b.lo[i]);
			hi = $signed(b.hi[i]);
			d = 0;
			if (c < lo)
				d = lo - c;
			else if (c > hi)
				d = c - hi;
			w = 130'(d);
			near_sq += w * w;
			// farthest corner per axis, no reordering of inverted spans
			m = (lo > c) ? lo - c : c - lo;
			d = (hi > c) ? hi - c : c - hi;
			if (d > m)
				m = d;
			w = 130'(m);
			far_sq += w * w;
		end
		if (near_sq >= rad_sq)
			return REL_OUTSIDE;
		if (b.mode == MODE_FAST)
			return REL_INSIDE;
		if (far_sq >= rad_sq)
			return REL_INTERSECTS;
		return REL_INSIDE;
	endfunction

	function automatic longint jitter(longint span);
		longint unsigned raw;
		raw = {$urandom, $urandom};
		if (span <= 0)
			return 0;
		return longint'(raw % longint'(2*span + 1)) - span;
	endfunction

	task automatic queue_box(bit mode, longint lx, longint ly, longint lz,
			longint hx, longint hy, longint hz);
		box_beat_t nb;
		nb.mode = mode;
		nb.lo = {CW'(lz), CW'(ly), CW'(lx)};
		nb.hi = {CW'(hz), CW'(hy), CW'(hx)};
		box_q.push_back(nb);
	endtask

	task automatic queue_random_boxes(int count);
		box_beat_t nb;
		longint c[3];
		longint r, sp, a, b, t;
		int kind;
		r = longint'(sphere_radius);
		for (int i = 0; i < 3; i++)
			c[i] = $signed(sphere_centre[i]);
		repeat (count) begin
			kind = $urandom_range(0, 9);
			nb.mode = $urandom_range(0, 1);
			case (kind)
				2, 3, 4: sp = r / 3;
				5, 6:    sp = r;
				default: sp = 2*r + 1;
			endcase
			for (int i = 0; i < 3; i++) begin
				if (kind < 2) begin
					nb.lo[i] = $urandom;
					nb.hi[i] = $urandom;
				end else begin
					a = c[i] + jitter(sp);
					b = c[i] + jitter(sp);
					if (a > b && kind != 9) begin
						t = a;
						a = b;
						b = t;
					end
					nb.lo[i] = CW'(a);
					nb.hi[i] = CW'(b);
				end
			end
			box_q.push_back(nb);
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_CENTER_X: sphere_centre[0] = val;
			CFG_CENTER_Y: sphere_centre[1] = val;
			CFG_CENTER_Z: sphere_centre[2] = val;
			CFG_RADIUS:   sphere_radius = val[CW-2:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
			logic [CW-1:0] rad);
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_CENTER_Z, cz);
		write_reg(CFG_RADIUS, rad);
	endtask

	task automatic wait_drained();
		while (box_q.size() != 0 || s_axis_tvalid || relation_q.size() != 0)
			@(negedge clk);
	endtask

	// beat source: bursts and gaps, holds a beat until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				relation_q.push_back(classify_box(beat_now));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (box_q.size() != 0) begin
					beat_next = box_q.pop_front();
					beat_now <= beat_next;
					s_axis_tdata <= TDATA_W'({beat_next.hi, beat_next.lo});
					s_axis_tuser <= beat_next.mode;
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink back-pressure
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE:     m_axis_tready <= 1'b1;
			RX_COIN:     m_axis_tready <= $urandom_range(0, 1);
			RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_axis_tready <= (rx_left % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		relation_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (relation_q.size() == 0) begin
				$error("relation: expected nothing, got %0d", m_axis_tdata);
				fail_count++;
			end else begin
				want = relation_q.pop_front();
				if (m_axis_tdata[1:0] !== want) begin
					$error("relation: expected %0d, got %0d", want, m_axis_tdata[1:0]);
					fail_count++;
				end
				if (m_axis_tdata[7:2] !== '0) begin
					$error("tdata pad: expected 0, got %0d", m_axis_tdata[7:2]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("tb_sphere_box_overlap_classifier_unit: errors");
		$finish;
	end

	initial begin
		longint cx, cy, cz;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset sphere has zero radius: everything lands outside
		queue_box(MODE_FULL, MINV, MINV, MINV, MAXV, MAXV, MAXV);
		queue_box(MODE_FAST, MINV, MINV, MINV, MAXV, MAXV, MAXV);
		queue_box(MODE_FULL, 0, 0, 0, 0, 0, 0);
		queue_box(MODE_FAST, 0, 0, 0, 0, 0, 0);

		wait_drained();
		cx = ONE;
		cy = 2*ONE;
		cz = -3*ONE;
		write_sphere(CW'(cx), CW'(cy), CW'(cz), CW'(4*ONE));
		queue_box(MODE_FULL, cx-ONE, cy-ONE, cz-ONE, cx+ONE, cy+ONE, cz+ONE);
		queue_box(MODE_FAST, cx-ONE, cy-ONE, cz-ONE, cx+ONE, cy+ONE, cz+ONE);
		queue_box(MODE_FULL, cx-10*ONE, cy-10*ONE, cz-10*ONE, cx+10*ONE, cy+10*ONE, cz+10*ONE);
		queue_box(MODE_FAST, cx-10*ONE, cy-10*ONE, cz-10*ONE, cx+10*ONE, cy+10*ONE, cz+10*ONE);
		queue_box(MODE_FULL, cx+5*ONE, cy, cz, cx+6*ONE, cy, cz);
		// touching at exactly the radius
		queue_box(MODE_FULL, cx+4*ONE, cy, cz, cx+5*ONE, cy, cz);
		queue_box(MODE_FULL, cx+4*ONE-1, cy, cz, cx+5*ONE, cy, cz);
		// far corner on the surface, then just short of it
		queue_box(MODE_FULL, cx, cy, cz, cx+4*ONE, cy, cz);
		queue_box(MODE_FULL, cx, cy, cz, cx+4*ONE-1, cy, cz);
		// inverted spans
		queue_box(MODE_FULL, cx+ONE, cy, cz, cx-ONE, cy, cz);
		queue_box(MODE_FULL, cx+3*ONE, cy, cz, cx+2*ONE, cy, cz);
		queue_box(MODE_FULL, cx, cy-2*ONE, cz, cx, cy-3*ONE, cz);
		queue_box(MODE_FULL, cx, cy, cz+5*ONE, cx, cy, cz-5*ONE);
		queue_box(MODE_FULL, MINV, MINV, MINV, MAXV, MAXV, MAXV);
		queue_box(MODE_FAST, MINV, MINV, MINV, MAXV, MAXV, MAXV);
		queue_box(MODE_FULL, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
		queue_box(MODE_FAST, MINV, MINV, MINV, MINV, MINV, MINV);
		queue_box(MODE_FULL, MAXV, MAXV, MAXV, MINV, MINV, MINV);
		queue_box(MODE_FAST, MAXV, MAXV, MAXV, MINV, MINV, MINV);

		for (int p = 0; p < 8; p++) begin
			wait_drained();
			case (p)
				0: write_sphere({1'b1, {CW-1{1'b0}}}, {1'b1, {CW-1{1'b0}}},
					{1'b1, {CW-1{1'b0}}}, {CW{1'b1}});
				1: write_sphere({1'b0, {CW-1{1'b1}}}, {1'b0, {CW-1{1'b1}}},
					{1'b0, {CW-1{1'b1}}}, {1'b0, {CW-1{1'b1}}});
				2: write_sphere($urandom, $urandom, $urandom, CW'(1));
				3: write_sphere('0, '0, '0, '0);
				default: write_sphere($urandom, $urandom, $urandom,
					$urandom >> $urandom_range(1, CW-1));
			endcase
			// unmapped index must leave the sphere alone
			write_reg($urandom_range(CFG_RADIUS + 1, (1 << CFG_INDEX_W) - 1), $urandom);
			queue_random_boxes(110);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_sphere_box_overlap_classifier_unit: clean");
		else
			$display("tb_sphere_box_overlap_classifier_unit: errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
design/sbo_pkg.sv
design/sbo_axis_span.sv
design/sbo_square.sv
design/sphere_box_overlap_classifier_unit.sv
design/sbo_checker.sv
dv/tb_sphere_box_overlap_classifier_unit.sv
